// ===== rtl/rps_pkg.sv =====
package rps_pkg;

  localparam int GridCells  = 4096;
  localparam int AddrW      = $clog2(GridCells);
  localparam int CellW      = 3;
  localparam int CfgW       = 13;
  localparam int CntW       = AddrW + 1;
  localparam int Neighbours = 8;
  localparam int NbrW       = $clog2(Neighbours);

  localparam logic [CellW-1:0] CellEmpty    = 3'b000;
  localparam logic [CellW-1:0] CellRock     = 3'b100;
  localparam logic [CellW-1:0] CellPaper    = 3'b010;
  localparam logic [CellW-1:0] CellScissors = 3'b001;

  localparam logic [CfgW-1:0] RowLengthReset   = 13'd64;
  localparam logic [CfgW-1:0] ActiveCellsReset = 13'd4096;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_ROW_LENGTH   = 1'b0,
    REG_ACTIVE_CELLS = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SELF,
    ST_SELF_WAIT,
    ST_SCAN,
    ST_PICK,
    ST_MOD,
    ST_WRITE_TGT,
    ST_WRITE_SELF,
    ST_READ_WAIT,
    ST_COPY,
    ST_OUT
  } state_e;

  // opponent test: does self beat other
  function automatic logic beats(input logic [CellW-1:0] self, input logic [CellW-1:0] other);
    logic [CellW-1:0] both;
    logic [CellW-1:0] win;
    begin
      both = self | other;
      if (both == (CellPaper | CellRock)) win = CellPaper;
      else if (both == (CellScissors | CellPaper)) win = CellScissors;
      else if (both == (CellRock | CellScissors)) win = CellRock;
      else win = CellEmpty;
      beats = (win == self);
    end
  endfunction

endpackage

// ===== rtl/rps_automaton_cell_step.sv =====
// One command per transfer, one result per command. The current and next
// grids each sit in a one-port-write, one-port-read RAM. After reset a
// clearing pass writes all 4096 entries of both grids before the first
// command is taken. Between the input transfer and the result, a load
// writes both grids and a read waits for the registered RAM output. A step
// reads the cell, then the eight neighbours one per cycle from both RAMs
// (pipelined), reduces the random value modulo the candidate count by
// repeated subtraction of the shifted count, then writes target and self.
// The reduction and writes are skipped when no neighbour qualifies, and the
// scan too on an empty or out-of-range cell. Commit copies next into
// current one entry a cycle. A finished result waits in an output register
// and holds off the next input transfer until it is taken.
module rps_automaton_cell_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], cell_addr[13:2], cell_value[16:14], random_value[32:17], zero pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value[2:0], moved[3], conquered[4], target_addr[16:5], zero pad
  output logic [23:0] m_axis_tdata
);
  import rps_pkg::*;

  logic [CfgW-1:0] row_q, act_q;
  state_e state_q, state_d;

  cmd_e             cmd_q, cmd_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CellW-1:0] val_q, val_d, self_q, self_d;
  logic [15:0]      rnd_q, rnd_d;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [CntW-1:0]  cnt_q, cnt_d;        // sweep counter
  logic [NbrW:0]    nidx_q, nidx_d;      // issued neighbour reads
  logic             rvld_q, rvld_d;      // a neighbour read is in flight
  logic             rok_q, rok_d;
  logic [AddrW-1:0] rat_q, rat_d;
  logic [AddrW-1:0] opp_q [Neighbours];
  logic [AddrW-1:0] fre_q [Neighbours];
  logic [NbrW:0]    nopp_q, nopp_d, nfre_q, nfre_d;
  logic             conq_q, conq_d;
  logic [NbrW:0]    div_q, div_d;
  logic [4:0]       mstep_q, mstep_d;
  logic [AddrW-1:0] tgt_q, tgt_d;
  logic             push_opp, push_fre;

  logic [23:0] out_q, out_d;
  logic        ovld_q, ovld_d;

  logic             cur_we, nxt_we;
  logic [AddrW-1:0] cur_wa, nxt_wa, cur_ra, nxt_ra;
  logic [CellW-1:0] cur_wd, nxt_wd, cur_rd, nxt_rd;

  rps_ram #(.Width(CellW), .Depth(GridCells)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_wa), .wdata_i(cur_wd),
    .raddr_i(cur_ra), .rdata_o(cur_rd)
  );
  rps_ram #(.Width(CellW), .Depth(GridCells)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(nxt_ra), .rdata_o(nxt_rd)
  );

  // neighbour address for the read being issued
  logic signed [CfgW+2:0] nb_at;
  logic signed [CfgW+2:0] rls;
  logic                   nb_ok;
  always_comb begin
    rls = signed'({3'b000, row_q});
    unique case (nidx_q[NbrW-1:0])
      3'd0: nb_at = signed'({4'b0, addr_q}) - rls - 16'sd1;
      3'd1: nb_at = signed'({4'b0, addr_q}) - rls;
      3'd2: nb_at = signed'({4'b0, addr_q}) - rls + 16'sd1;
      3'd3: nb_at = signed'({4'b0, addr_q}) - 16'sd1;
      3'd4: nb_at = signed'({4'b0, addr_q}) + 16'sd1;
      3'd5: nb_at = signed'({4'b0, addr_q}) + rls - 16'sd1;
      3'd6: nb_at = signed'({4'b0, addr_q}) + rls;
      default: nb_at = signed'({4'b0, addr_q}) + rls + 16'sd1;
    endcase
    nb_ok = (nb_at >= 0) && (nb_at < signed'({3'b0, limit_q}));
  end

  logic [NbrW:0] ncand;
  logic [20:0]   dsh;
  always_comb begin
    ncand = (nopp_q != '0) ? nopp_q : nfre_q;
    dsh   = {17'd0, div_q} << (5'd15 - 5'(mstep_q));
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; addr_d = addr_q; val_d = val_q; self_d = self_q;
    rnd_d = rnd_q; limit_d = limit_q; cnt_d = cnt_q; nidx_d = nidx_q;
    rvld_d = 1'b0; rok_d = rok_q; rat_d = rat_q;
    nopp_d = nopp_q; nfre_d = nfre_q; conq_d = conq_q; div_d = div_q;
    mstep_d = mstep_q; tgt_d = tgt_q;
    out_d = out_q; ovld_d = ovld_q;
    push_opp = 1'b0; push_fre = 1'b0;
    cur_we = 1'b0; nxt_we = 1'b0;
    cur_wa = addr_q; nxt_wa = addr_q; cur_wd = val_q; nxt_wd = val_q;
    cur_ra = addr_q; nxt_ra = addr_q;
    s_axis_tready = 1'b0;

    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cur_we = 1'b1; nxt_we = 1'b1;
        cur_wa = cnt_q[AddrW-1:0]; nxt_wa = cnt_q[AddrW-1:0];
        cur_wd = CellEmpty; nxt_wd = CellEmpty;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[AddrW-1:0] == AddrW'(GridCells - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = !ovld_q;
        if (s_axis_tvalid && !ovld_q) begin
          cmd_d  = cmd_e'(s_axis_tdata[1:0]);
          addr_d = s_axis_tdata[13:2];
          val_d  = s_axis_tdata[16:14];
          rnd_d  = s_axis_tdata[32:17];
          limit_d = (act_q > CfgW'(GridCells)) ? CntW'(GridCells) : act_q[CntW-1:0];
          out_d = '0;
          unique case (cmd_e'(s_axis_tdata[1:0]))
            CMD_LOAD: begin
              cur_we = 1'b1; nxt_we = 1'b1;
              cur_wa = s_axis_tdata[13:2]; nxt_wa = s_axis_tdata[13:2];
              cur_wd = s_axis_tdata[16:14]; nxt_wd = s_axis_tdata[16:14];
              state_d = ST_OUT;
            end
            CMD_READ: begin
              cur_ra = s_axis_tdata[13:2];
              state_d = ST_READ_WAIT;
            end
            CMD_COMMIT: begin
              cnt_d = '0;
              nxt_ra = '0;
              state_d = ST_COPY;
            end
            default: state_d = ST_SELF;
          endcase
        end
      end
      ST_READ_WAIT: begin
        out_d[2:0] = cur_rd;
        state_d = ST_OUT;
      end
      ST_COPY: begin
        // read of entry cnt was issued last cycle
        cur_we = 1'b1;
        cur_wa = cnt_q[AddrW-1:0];
        cur_wd = nxt_rd;
        nxt_ra = cnt_q[AddrW-1:0] + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[AddrW-1:0] == AddrW'(GridCells - 1)) state_d = ST_OUT;
      end
      ST_SELF: begin
        cur_ra = addr_q;
        state_d = ST_SELF_WAIT;
      end
      ST_SELF_WAIT: begin
        self_d = cur_rd;
        nidx_d = '0; nopp_d = '0; nfre_d = '0;
        if ({1'b0, addr_q} < limit_q && cur_rd != CellEmpty) state_d = ST_SCAN;
        else state_d = ST_OUT;
      end
      ST_SCAN: begin
        // issue one neighbour read a cycle, evaluate the previous one
        if (rvld_q && rok_q && cur_rd != self_q) begin
          if (nxt_rd == CellEmpty) begin
            push_fre = 1'b1; nfre_d = nfre_q + 1'b1;
          end
          if (beats(self_q, cur_rd)) begin
            push_opp = 1'b1; nopp_d = nopp_q + 1'b1;
          end
        end
        if (nidx_q != (NbrW+1)'(Neighbours)) begin
          cur_ra = nb_at[AddrW-1:0];
          nxt_ra = nb_at[AddrW-1:0];
          rat_d = nb_at[AddrW-1:0];
          rok_d = nb_ok;
          rvld_d = 1'b1;
          nidx_d = nidx_q + 1'b1;
        end else if (!rvld_q) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        conq_d = (nopp_q != '0);
        div_d = ncand;
        mstep_d = '0;
        if (ncand == '0) state_d = ST_OUT;
        else state_d = ST_MOD;
      end
      ST_MOD: begin
        // restoring remainder: one shifted subtract a cycle
        if ({5'd0, rnd_q} >= dsh) rnd_d = rnd_q - dsh[15:0];
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == 5'd15) state_d = ST_WRITE_TGT;
      end
      ST_WRITE_TGT: begin
        tgt_d = conq_q ? opp_q[rnd_q[NbrW-1:0]] : fre_q[rnd_q[NbrW-1:0]];
        nxt_we = 1'b1;
        nxt_wa = conq_q ? opp_q[rnd_q[NbrW-1:0]] : fre_q[rnd_q[NbrW-1:0]];
        nxt_wd = self_q;
        state_d = ST_WRITE_SELF;
      end
      ST_WRITE_SELF: begin
        nxt_we = 1'b1; nxt_wa = addr_q; nxt_wd = CellEmpty;
        out_d = {7'd0, tgt_q, conq_q, 1'b1, 3'd0};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        ovld_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      rvld_q  <= 1'b0;
      row_q   <= RowLengthReset;
      act_q   <= ActiveCellsReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      rvld_q  <= rvld_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_ROW_LENGTH:   row_q <= cfg_wdata_i;
          REG_ACTIVE_CELLS: act_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; addr_q <= addr_d; val_q <= val_d; self_q <= self_d;
    rnd_q <= rnd_d; limit_q <= limit_d; nidx_q <= nidx_d;
    rok_q <= rok_d; rat_q <= rat_d; nopp_q <= nopp_d; nfre_q <= nfre_d;
    conq_q <= conq_d; div_q <= div_d; mstep_q <= mstep_d; tgt_q <= tgt_d;
    out_q <= out_d;
    if (push_opp) opp_q[nopp_q[NbrW-1:0]] <= rat_q;
    if (push_fre) fre_q[nfre_q[NbrW-1:0]] <= rat_q;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  // a pending result blocks new commands
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept with result held");
  // remainder stays below the candidate count at the pick
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE_TGT |-> {3'd0, rnd_q[NbrW:0]} < {3'd0, div_q} && rnd_q[15:NbrW+1] == '0)
    else $error("remainder out of range");
  // the opponent count never exceeds the neighbour count at the pick
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nopp_q <= (NbrW+1)'(Neighbours) || state_q != ST_PICK) else $error("count overflow");
  // the self write is always followed by the result
  a_move_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE_SELF |=> state_q == ST_OUT) else $error("step write order");

endmodule

// ===== rtl/rps_ram.sv =====
module rps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
